// ===== rtl/mbts_pkg.sv =====
// Package for the register server: payload structs, sizes, opcodes and codes
// shared by the controller, datapath and top level. No dependencies.
`default_nettype none
package mbts_pkg;

  localparam int WrWords = 64;
  localparam int RdWords = 64;
  localparam int TotalWords = WrWords + RdWords;
  localparam int MaxPdu = 253;
  localparam int MaxReadQty = 125;
  localparam int AddrW = 7;

  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_CTL = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  localparam logic [7:0] FN_READ = 8'h03;
  localparam logic [7:0] FN_WRITE = 8'h06;
  localparam logic [7:0] EXC_FLAG = 8'h80;
  localparam logic [7:0] EXC_FUNC = 8'h01;
  localparam logic [7:0] EXC_ADDR = 8'h02;
  localparam logic [7:0] EXC_VALUE = 8'h03;

  localparam logic [0:0] CFG_MODE_CODE = 1'b0;
  localparam logic [0:0] CFG_MODE_ADDR = 1'b1;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  rx_byte;
    logic [5:0]  ctl_index;
    logic [15:0] ctl_value;
  } req_t;

  typedef struct packed {
    logic [63:0] beat_data;
    logic [3:0]  beat_bytes;
    logic        beat_last;
    logic        drop_connection;
    logic        wr_strobe;
    logic [5:0]  wr_addr;
    logic [15:0] wr_value;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic take;      // capture input beat
    logic answer;    // start building response
    logic rd_step;   // read next word into byte queue
    logic push_beat; // load output register
    logic drop;      // emit drop beat
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_answer;
    logic need_drop;
    logic words_left;
    logic beat_ready;
    logic beat_final;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/modbus_tcp_register_server_core.sv =====
// Modbus TCP register server (functions 3 and 6): controller and datapath.
// Depends on mbts_pkg, mbts_ctrl and mbts_dp.
//
// Input channel in_valid_i/in_ready_o carries one event per beat: a request
// byte, a controller word update or a connection restart. Output channel
// out_valid_o/out_ready_i carries response beats of up to eight bytes, or a
// single drop beat on a bad header. One event at a time: an event with no
// response returns to idle after evaluation; a bad header loads the drop
// beat once the output is free; the last byte of a request builds an answer,
// each word read from a registered store port before it enters the byte
// queue, then emits output beats. A stalled receiver holds the
// output register and the controller waits. Reset clears parser and stores,
// turns remote control on and restores the configuration defaults.
// Configuration writes via cfg_we_i/cfg_idx_i/cfg_data_i take effect at once.
`default_nettype none
module modbus_tcp_register_server_core import mbts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  req_t        in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output rsp_t        out_data_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  mbts_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .sts_i(sts), .cmd_o(cmd)
  );

  mbts_dp u_dp (
    .clk_i, .rst_ni, .req_i(in_data_i), .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .cmd_i(cmd), .sts_o(sts), .out_valid_o, .out_ready_i, .out_o(out_data_o)
  );

endmodule
`default_nettype wire

// ===== rtl/mbts_ctrl.sv =====
// Controller: sequences accept, answer build, word reads and beat emission.
// Depends on mbts_pkg.
`default_nettype none
module mbts_ctrl import mbts_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EVAL = 3'd1;
  localparam logic [2:0] ST_BUILD = 3'd2;
  localparam logic [2:0] ST_RUN = 3'd3;
  localparam logic [2:0] ST_DROP = 3'd4;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (sts_i.need_drop) state_d = ST_DROP;
        else if (sts_i.need_answer) begin
          cmd_o.answer = 1'b1;
          state_d = ST_BUILD;
        end else state_d = ST_IDLE;
      end
      ST_DROP: begin
        if (sts_i.out_free) begin
          cmd_o.drop = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_RUN: begin
        if (sts_i.beat_ready) begin
          if (sts_i.out_free) begin
            cmd_o.push_beat = 1'b1;
            if (sts_i.beat_final) state_d = ST_IDLE;
          end
        end else if (sts_i.words_left) begin
          cmd_o.rd_step = 1'b1;
          state_d = ST_BUILD;
        end
      end
      // wait for the registered store read
      ST_BUILD: state_d = ST_RUN;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.take, cmd_o.answer, cmd_o.rd_step, cmd_o.push_beat, cmd_o.drop}))
    else $error("several commands at once");
  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.take |-> state_q == ST_IDLE)
    else $error("take outside idle");
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.push_beat || cmd_o.drop) |-> sts_i.out_free)
    else $error("beat pushed into full output");
`endif

endmodule
`default_nettype wire

// ===== rtl/mbts_dp.sv =====
// Datapath: parser registers, word stores, response byte queue, output beat.
// Depends on mbts_pkg.
`default_nettype none
module mbts_dp import mbts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  req_t        req_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output rsp_t        out_o
);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_PDU = 2'd1;
  localparam logic [1:0] PH_DROPPED = 2'd2;

  logic [15:0] mode_code_q;
  logic [5:0]  mode_addr_q;
  logic [55:0] hdr_q;
  logic [39:0] pdu_q;
  logic [8:0]  cnt_q;
  logic [1:0]  phase_q;
  logic        remote_q;
  logic        need_ans_q, need_drop_q;
  logic [15:0] wmem [WrWords];
  logic [15:0] rmem [RdWords];
  logic [WrWords-1:0] wvalid_q;
  logic [RdWords-1:0] rvalid_q;

  // byte queue: up to 15 bytes, earliest in top
  logic [119:0] q_q;
  logic [3:0]   qn_q;
  logic [6:0]   left_q;   // words still to read
  logic [AddrW:0] raddr_q;
  logic         wr_q;
  logic [5:0]   wa_q;
  logic [15:0]  wv_q;
  logic         ovalid_q;
  rsp_t         obuf_q;
  logic [15:0]  rd_word_q;
  logic [15:0]  mode_rd_q;

  logic [15:0] pdu_len, f1, f2;
  logic [7:0]  func;
  assign pdu_len = hdr_q[23:8] - 16'd1;
  assign func = pdu_q[39:32];
  assign f1 = pdu_q[31:16];
  assign f2 = pdu_q[15:0];

  assign out_valid_o = ovalid_q;
  assign out_o = obuf_q;
  assign sts_o.need_answer = need_ans_q;
  assign sts_o.need_drop = need_drop_q;
  assign sts_o.words_left = (left_q != '0);
  assign sts_o.beat_ready = (qn_q >= 4'd8) || (left_q == '0);
  assign sts_o.beat_final = (left_q == '0) && (qn_q <= 4'd8);
  assign sts_o.out_free = !ovalid_q || out_ready_i;

  logic [AddrW-1:0] ra;
  assign ra = raddr_q[AddrW-1:0];

  logic [55:0] hdr_n;
  assign hdr_n = {hdr_q[47:0], req_i.rx_byte};

  // end of header or of request on this byte
  logic hdr_done, hdr_bad, take_ans, take_drop;
  assign hdr_done = (phase_q == PH_HEADER) && (cnt_q == 9'd6);
  assign hdr_bad = (hdr_n[39:24] != '0) || (hdr_n[23:8] == '0)
    || (hdr_n[23:8] > 16'(MaxPdu + 1));
  assign take_drop = (req_i.operation == OP_BYTE) && hdr_done && hdr_bad;
  assign take_ans = (req_i.operation == OP_BYTE)
    && ((hdr_done && !hdr_bad && hdr_n[23:8] == 16'd1)
        || (phase_q == PH_PDU && ({7'd0, cnt_q} + 16'd2 >= hdr_q[23:8])));

  // answer evaluation
  logic [7:0]  exc;
  logic [16:0] rd_end;
  logic        do_wr;
  logic [15:0] mode_val;
  assign rd_end = {1'b0, f1} + {1'b0, f2};
  assign do_wr = (func == FN_WRITE) && (pdu_len == 16'd5) && (f1 < 16'(TotalWords))
    && (f1 < 16'(WrWords)) && ((f1[5:0] == mode_addr_q) || remote_q);
  always_comb begin
    exc = '0;
    if (func == FN_READ) begin
      if (pdu_len < 16'd5 || f2 == '0 || f2 > 16'(MaxReadQty)) exc = EXC_VALUE;
      else if (rd_end > 17'(TotalWords)) exc = EXC_ADDR;
    end else if (func == FN_WRITE) begin
      if (pdu_len != 16'd5) exc = EXC_VALUE;
      else if (f1 >= 16'(TotalWords)) exc = EXC_ADDR;
    end else exc = EXC_FUNC;
    if (do_wr && f1[5:0] == mode_addr_q) mode_val = f2;
    else mode_val = mode_rd_q;
  end

  logic [15:0] rl;
  always_comb begin
    if (exc != '0) rl = 16'd2;
    else if (func == FN_READ) rl = 16'd2 + {f2[14:0], 1'b0};
    else rl = 16'd5;
  end

  logic [63:0]  q_tail;
  logic [119:0] q_init;
  always_comb begin
    if (exc != '0) q_tail = {func | EXC_FLAG, exc, 48'h0};
    else if (func == FN_READ) q_tail = {FN_READ, f2[6:0], 1'b0, 48'h0};
    else q_tail = {FN_WRITE, f1, f2, 24'h0};
  end
  assign q_init = {hdr_q[55:40], 16'h0000, rl + 16'd1, hdr_q[7:0], q_tail};

  logic [63:0] beat;
  logic [3:0]  bn;
  assign bn = (qn_q > 4'd8) ? 4'd8 : qn_q;
  always_comb begin
    beat = q_q[119:56];
    for (int j = 0; j < 8; j++) if (4'(j) >= bn) beat[63-8*j -: 8] = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_code_q <= 16'd2015;
      mode_addr_q <= 6'd5;
      hdr_q <= '0;
      pdu_q <= '0;
      cnt_q <= '0;
      phase_q <= PH_HEADER;
      remote_q <= 1'b1;
      need_ans_q <= 1'b0;
      need_drop_q <= 1'b0;
      wvalid_q <= '0;
      rvalid_q <= '0;
      qn_q <= '0;
      left_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_MODE_CODE) mode_code_q <= cfg_data_i;
        else mode_addr_q <= cfg_data_i[5:0];
      end
      if (cmd_i.push_beat || cmd_i.drop) ovalid_q <= 1'b1;
      else if (ovalid_q && out_ready_i) ovalid_q <= 1'b0;
      if (cmd_i.take) begin
        need_ans_q <= take_ans;
        need_drop_q <= take_drop;
        unique case (req_i.operation)
          OP_CTL: rvalid_q[req_i.ctl_index] <= 1'b1;
          OP_RESTART: begin
            hdr_q <= '0; pdu_q <= '0; cnt_q <= '0; phase_q <= PH_HEADER;
          end
          OP_BYTE: begin
            if (phase_q == PH_HEADER) begin
              hdr_q <= hdr_n;
              if (cnt_q == 9'd6) begin
                cnt_q <= '0;
                pdu_q <= '0;
                if (hdr_bad) phase_q <= PH_DROPPED;
                else if (hdr_n[23:8] != 16'd1) phase_q <= PH_PDU;
              end else cnt_q <= cnt_q + 9'd1;
            end else if (phase_q == PH_PDU) begin
              if (cnt_q < 9'd5) pdu_q[8*(4-cnt_q[2:0]) +: 8] <= req_i.rx_byte;
              cnt_q <= cnt_q + 9'd1;
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.drop) begin
        need_drop_q <= 1'b0;
      end
      if (cmd_i.answer) begin
        need_ans_q <= 1'b0;
        hdr_q <= '0; pdu_q <= '0; cnt_q <= '0; phase_q <= PH_HEADER;
        if (exc == '0 && func == FN_WRITE) begin
          if (do_wr) wvalid_q[f1[5:0]] <= 1'b1;
          remote_q <= ({1'b0, mode_addr_q} < 7'(WrWords)) ? (mode_val != mode_code_q)
                                                          : (mode_code_q != '0);
        end
        if (exc == '0 && func == FN_READ) begin
          qn_q <= 4'd9;
          left_q <= f2[6:0];
        end else if (exc == '0) begin
          qn_q <= 4'd12;
          left_q <= '0;
        end else begin
          qn_q <= 4'd9;
          left_q <= '0;
        end
      end
      if (cmd_i.rd_step) begin
        qn_q <= qn_q + 4'd2;
        left_q <= left_q - 7'd1;
      end
      if (cmd_i.push_beat) begin
        qn_q <= qn_q - bn;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && req_i.operation == OP_CTL) rmem[req_i.ctl_index] <= req_i.ctl_value;
    if (cmd_i.answer && do_wr && exc == '0) wmem[f1[5:0]] <= f2;
    // registered store reads
    if (raddr_q[AddrW]) rd_word_q <= '0;
    else if (ra < AddrW'(WrWords)) rd_word_q <= wvalid_q[ra[5:0]] ? wmem[ra[5:0]] : '0;
    else rd_word_q <= rvalid_q[ra[5:0]] ? rmem[ra[5:0]] : '0;
    mode_rd_q <= wvalid_q[mode_addr_q] ? wmem[mode_addr_q] : '0;
    if (cmd_i.drop) begin
      obuf_q <= '{beat_last: 1'b1, drop_connection: 1'b1, default: '0};
    end else if (cmd_i.push_beat) begin
      obuf_q <= '{beat_data: beat,
                  beat_bytes: bn,
                  beat_last: sts_o.beat_final,
                  drop_connection: 1'b0,
                  wr_strobe: sts_o.beat_final && wr_q,
                  wr_addr: (sts_o.beat_final && wr_q) ? wa_q : 6'd0,
                  wr_value: (sts_o.beat_final && wr_q) ? wv_q : 16'd0};
    end
    if (cmd_i.answer) begin
      wr_q <= do_wr && exc == '0;
      wa_q <= f1[5:0];
      wv_q <= f2;
    end
    if (cmd_i.answer) raddr_q <= f1[AddrW:0];
    else if (cmd_i.rd_step) raddr_q <= raddr_q + 1'b1;
    if (cmd_i.answer) q_q <= q_init;
    else if (cmd_i.rd_step) q_q[119 - 8*qn_q -: 16] <= rd_word_q;
    else if (cmd_i.push_beat) q_q <= q_q << (8*bn);
  end

`ifndef NO_ASSERTIONS
  a_queue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_step |-> qn_q <= 4'd13)
    else $error("byte queue overflow");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !out_ready_i) |=> $stable(obuf_q))
    else $error("output changed while stalled");
  a_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != 2'd3)
    else $error("bad parse phase");
`endif

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench for the register server core: request streams, controller word
// updates and restarts, with response beats checked against a built-in model.
// Depends on mbts_pkg and modbus_tcp_register_server_core.
module tb_top;
  import mbts_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  req_t        in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  rsp_t        out_data_o;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [15:0] cfg_data_i;

  modbus_tcp_register_server_core DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  // server model state
  logic [15:0] mode_code;
  logic [5:0]  mode_addr;
  logic [55:0] hdr_shift;
  logic [39:0] pdu_first;
  int unsigned nbytes;
  int unsigned phase;  // 0 header, 1 pdu, 2 dropped
  logic [15:0] wr_mem [WrWords];
  logic [15:0] rd_mem [RdWords];
  logic        remote_on;

  rsp_t beats_due[$];
  int   errors;
  int   idle_cycles;
  bit   hold_off;
  bit   sender_bursty;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [15:0] fetch_word(int unsigned a);
    if (a < WrWords) return wr_mem[a];
    if (a - WrWords < RdWords) return rd_mem[a - WrWords];
    return 16'h0;
  endfunction

  task automatic push_bytes(ref logic [7:0] b[$], input bit wr,
                            input logic [5:0] wa, input logic [15:0] wv);
    int n;
    int k;
    int j;
    rsp_t r;
    n = b.size();
    for (k = 0; k < (n + 7) / 8; k++) begin
      r = '0;
      for (j = 0; j < 8 && k * 8 + j < n; j++) r.beat_data[63 - 8 * j -: 8] = b[k * 8 + j];
      r.beat_bytes = 4'(j);
      r.beat_last = (k + 1 == (n + 7) / 8);
      if (r.beat_last && wr) begin
        r.wr_strobe = 1'b1;
        r.wr_addr = wa;
        r.wr_value = wv;
      end
      beats_due.push_back(r);
    end
  endtask

  task automatic build_answer();
    logic [7:0]  b[$];
    int unsigned plen;
    int unsigned rl;
    logic [7:0]  fn;
    int unsigned f1;
    int unsigned f2;
    logic [7:0]  exc;
    bit          wr;
    logic [15:0] w;
    logic [15:0] mv;
    plen = hdr_shift[23:8] - 1;
    fn = pdu_first[39:32];
    f1 = pdu_first[31:16];
    f2 = pdu_first[15:0];
    exc = 8'h0;
    wr = 1'b0;
    b = '{8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0, 8'h0};
    if (fn == FN_READ) begin
      if (plen < 5 || f2 == 0 || f2 > MaxReadQty) exc = EXC_VALUE;
      else if (f1 + f2 > TotalWords) exc = EXC_ADDR;
      else begin
        b.push_back(FN_READ);
        b.push_back(8'(f2 * 2));
        for (int i = 0; i < f2; i++) begin
          w = fetch_word(f1 + i);
          b.push_back(w[15:8]);
          b.push_back(w[7:0]);
        end
      end
    end else if (fn == FN_WRITE) begin
      if (plen != 5) exc = EXC_VALUE;
      else if (f1 >= TotalWords) exc = EXC_ADDR;
      else begin
        if ((f1 == mode_addr || remote_on) && f1 < WrWords) begin
          wr_mem[f1] = f2[15:0];
          wr = 1'b1;
        end
        mv = (mode_addr < WrWords) ? wr_mem[mode_addr] : 16'h0;
        remote_on = (mv != mode_code);
        b.push_back(FN_WRITE);
        b.push_back(8'(f1 >> 8));
        b.push_back(8'(f1));
        b.push_back(8'(f2 >> 8));
        b.push_back(8'(f2));
      end
    end else exc = EXC_FUNC;
    if (exc != 0) begin
      b.push_back(fn | EXC_FLAG);
      b.push_back(exc);
    end
    rl = b.size() - 7;
    b[0] = hdr_shift[55:48];
    b[1] = hdr_shift[47:40];
    b[4] = 8'((1 + rl) >> 8);
    b[5] = 8'(1 + rl);
    b[6] = hdr_shift[7:0];
    push_bytes(b, wr, 6'(f1), wr ? f2[15:0] : 16'h0);
    hdr_shift = '0;
    pdu_first = '0;
    nbytes = 0;
    phase = 0;
  endtask

  task automatic predict_event(req_t e);
    rsp_t d;
    if (e.operation == OP_CTL) begin
      rd_mem[e.ctl_index] = e.ctl_value;
    end else if (e.operation == OP_RESTART) begin
      hdr_shift = '0;
      pdu_first = '0;
      nbytes = 0;
      phase = 0;
    end else if (e.operation == OP_BYTE && phase != 2) begin
      if (phase == 0) begin
        hdr_shift = {hdr_shift[47:0], e.rx_byte};
        nbytes++;
        if (nbytes == 7) begin
          nbytes = 0;
          pdu_first = '0;
          if (hdr_shift[39:24] != 0 || hdr_shift[23:8] < 1 ||
              hdr_shift[23:8] > MaxPdu + 1) begin
            phase = 2;
            d = '0;
            d.beat_last = 1'b1;
            d.drop_connection = 1'b1;
            beats_due.push_back(d);
          end else if (hdr_shift[23:8] == 1) build_answer();
          else phase = 1;
        end
      end else begin
        if (nbytes < 5) pdu_first[8 * (4 - nbytes) +: 8] = e.rx_byte;
        nbytes++;
        if (nbytes + 1 >= hdr_shift[23:8]) build_answer();
      end
    end
  endtask

  // one beat on the input channel, predicted when accepted
  task automatic send_event(req_t e);
    @(negedge clk_i);
    if (sender_bursty && $urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= e;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_event(e);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic send_raw(logic [7:0] v);
    req_t e;
    e = '0;
    e.operation = OP_BYTE;
    e.rx_byte = v;
    e.ctl_index = 6'($urandom());
    e.ctl_value = 16'($urandom());
    send_event(e);
  endtask

  task automatic send_ctl(logic [5:0] idx, logic [15:0] val);
    req_t e;
    e = '0;
    e.operation = OP_CTL;
    e.rx_byte = 8'($urandom());
    e.ctl_index = idx;
    e.ctl_value = val;
    send_event(e);
  endtask

  task automatic send_op(logic [1:0] op);
    req_t e;
    e.operation = op;
    e.rx_byte = 8'($urandom());
    e.ctl_index = 6'($urandom());
    e.ctl_value = 16'($urandom());
    send_event(e);
  endtask

  task automatic send_header(logic [15:0] tid, logic [15:0] proto, logic [15:0] len,
                             logic [7:0] unit);
    send_raw(tid[15:8]); send_raw(tid[7:0]);
    send_raw(proto[15:8]); send_raw(proto[7:0]);
    send_raw(len[15:8]); send_raw(len[7:0]);
    send_raw(unit);
  endtask

  task automatic send_request(logic [7:0] fn, logic [15:0] a, logic [15:0] v,
                              int unsigned plen);
    logic [7:0] pdu[5];
    pdu = '{fn, a[15:8], a[7:0], v[15:8], v[7:0]};
    send_header(16'($urandom()), 16'h0, 16'(plen + 1), 8'($urandom()));
    for (int i = 0; i < plen; i++) send_raw(i < 5 ? pdu[i] : 8'($urandom()));
  endtask

  task automatic wait_drained();
    while (beats_due.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_MODE_CODE) mode_code = val;
    else mode_addr = val[5:0];
  endtask

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (beats_due.size() == 0) begin
        $display("%0t unexpected beat exp none got %h", $time, out_data_o);
        errors++;
      end else begin
        rsp_t x;
        x = beats_due.pop_front();
        if (x.beat_data !== out_data_o.beat_data)
          $display("%0t beat_data exp %h got %h", $time, x.beat_data, out_data_o.beat_data);
        if (x.beat_bytes !== out_data_o.beat_bytes)
          $display("%0t beat_bytes exp %0d got %0d", $time, x.beat_bytes,
                   out_data_o.beat_bytes);
        if (x.beat_last !== out_data_o.beat_last)
          $display("%0t beat_last exp %b got %b", $time, x.beat_last, out_data_o.beat_last);
        if (x.drop_connection !== out_data_o.drop_connection)
          $display("%0t drop exp %b got %b", $time, x.drop_connection,
                   out_data_o.drop_connection);
        if (x.wr_strobe !== out_data_o.wr_strobe)
          $display("%0t wr_strobe exp %b got %b", $time, x.wr_strobe, out_data_o.wr_strobe);
        if (x.wr_addr !== out_data_o.wr_addr)
          $display("%0t wr_addr exp %h got %h", $time, x.wr_addr, out_data_o.wr_addr);
        if (x.wr_value !== out_data_o.wr_value)
          $display("%0t wr_value exp %h got %h", $time, x.wr_value, out_data_o.wr_value);
        if (x !== out_data_o) errors++;
      end
    end
  end

  // receiver stall pattern
  initial begin
    int ph;
    out_ready_i = 1'b0;
    ph = 0;
    forever begin
      @(negedge clk_i);
      ph++;
      if (hold_off) out_ready_i <= 1'b0;
      else if (ph % 64 < 20) out_ready_i <= 1'b1;
      else out_ready_i <= ($urandom_range(0, 3) != 0) && (ph % 7 != 3);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  task automatic test_header_checks();
    send_request(FN_READ, 16'd0, 16'd1, 5);
    send_header(16'hFFFF, 16'h0, 16'd1, 8'hFF);              // empty pdu
    send_header(16'h1234, 16'h0001, 16'd6, 8'h01);           // bad protocol
    send_raw(8'hAA);                                          // ignored after drop
    send_op(OP_RESTART);
    send_header(16'h0, 16'h0, 16'd0, 8'h0);                   // zero length
    send_op(OP_RESTART);
    send_header(16'h0, 16'h0, 16'd256, 8'h0);                 // length too big
    send_op(OP_RESTART);
    send_op(2'd3);
  endtask

  task automatic test_reads();
    send_ctl(6'd0, 16'hFFFF);
    send_ctl(6'd63, 16'h8001);
    send_request(FN_READ, 16'd0, 16'd125, 5);
    send_request(FN_READ, 16'd3, 16'd125, 5);                 // at the limit
    send_request(FN_READ, 16'd4, 16'd125, 5);                 // beyond space
    send_request(FN_READ, 16'd0, 16'd0, 5);
    send_request(FN_READ, 16'd0, 16'd126, 5);
    send_request(FN_READ, 16'd0, 16'd2, 4);                   // short pdu
    send_request(FN_READ, 16'd126, 16'd2, 9);                 // trailing bytes
    send_request(8'hFF, 16'd0, 16'd1, 5);
  endtask

  task automatic test_writes();
    send_request(FN_WRITE, 16'd10, 16'hBEEF, 5);
    send_request(FN_WRITE, 16'd100, 16'h1111, 5);             // readable area
    send_request(FN_WRITE, 16'd128, 16'h1, 5);
    send_request(FN_WRITE, 16'd10, 16'h1, 4);
    send_request(FN_WRITE, 16'(mode_addr), mode_code, 5);     // remote off
    send_request(FN_WRITE, 16'd11, 16'h2222, 5);              // not stored
    send_request(FN_WRITE, 16'(mode_addr), 16'h0, 5);         // remote on
    send_request(FN_READ, 16'd0, 16'd16, 5);
    wait_drained();
  endtask

  task automatic test_config();
    write_cfg(CFG_MODE_CODE, 16'hFFFF);
    write_cfg(CFG_MODE_ADDR, 16'd63);
    send_request(FN_WRITE, 16'd63, 16'hFFFF, 5);
    send_request(FN_WRITE, 16'd1, 16'h5, 5);
    send_request(FN_WRITE, 16'd63, 16'h0, 5);
    wait_drained();
    write_cfg(CFG_MODE_CODE, 16'h0);
    write_cfg(CFG_MODE_ADDR, 16'd0);
    send_request(FN_WRITE, 16'd0, 16'h0, 5);
    send_request(FN_WRITE, 16'd2, 16'h7, 5);
    send_request(FN_WRITE, 16'd0, 16'h9, 5);
    wait_drained();
    write_cfg(CFG_MODE_CODE, 16'd2015);
    write_cfg(CFG_MODE_ADDR, 16'd5);
  endtask

  task automatic test_stall();
    hold_off = 1'b1;
    fork
      begin
        repeat (400) @(negedge clk_i);
        hold_off = 1'b0;
      end
      repeat (2) send_request(FN_READ, 16'($urandom_range(0, 60)), 16'd40, 5);
    join
    wait_drained();
  endtask

  task automatic test_random(int unsigned n);
    int unsigned sent;
    int unsigned k;
    sent = 0;
    while (sent < n) begin
      k = $urandom_range(0, 19);
      if (k < 8) begin
        send_request(FN_READ, 16'($urandom_range(0, 130)),
                     16'($urandom_range(0, 3) == 0 ? $urandom_range(0, 126)
                                                  : $urandom_range(1, 12)),
                     $urandom_range(0, 7) == 0 ? $urandom_range(1, 8) : 5);
        sent += 12;
      end else if (k < 14) begin
        send_request($urandom_range(0, 5) == 0 ? FN_WRITE : FN_WRITE,
                     16'($urandom_range(0, 9) == 0 ? $urandom() : $urandom_range(0, 70)),
                     $urandom_range(0, 4) == 0 ? mode_code : 16'($urandom()),
                     $urandom_range(0, 9) == 0 ? $urandom_range(1, 7) : 5);
        sent += 12;
      end else if (k < 16) begin
        send_ctl(6'($urandom()), 16'($urandom()));
        sent++;
      end else if (k < 17) begin
        send_header(16'($urandom()), 16'($urandom_range(0, 1) ? 0 : $urandom()),
                    16'($urandom()), 8'($urandom()));
        send_op(OP_RESTART);
        sent += 8;
      end else if (k < 18) begin
        send_request(8'($urandom()), 16'($urandom()), 16'($urandom()),
                     $urandom_range(1, 6));
        sent += 10;
      end else begin
        send_raw(8'($urandom()));
        send_op(OP_RESTART);
        sent += 2;
      end
    end
  endtask

  initial begin
    errors = 0;
    idle_cycles = 0;
    hold_off = 1'b0;
    sender_bursty = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = 1'b0;
    cfg_data_i = '0;
    mode_code = 16'd2015;
    mode_addr = 6'd5;
    hdr_shift = '0;
    pdu_first = '0;
    nbytes = 0;
    phase = 0;
    remote_on = 1'b1;
    foreach (wr_mem[i]) wr_mem[i] = 16'h0;
    foreach (rd_mem[i]) rd_mem[i] = 16'h0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_header_checks();
    test_reads();
    test_writes();
    test_config();
    test_stall();
    sender_bursty = 1'b1;
    test_random(12);
    wait_drained();
    write_cfg(CFG_MODE_CODE, 16'($urandom()));
    write_cfg(CFG_MODE_ADDR, 16'($urandom()));
    test_random(12);
    wait_drained();
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/mbts_pkg.sv
rtl/mbts_ctrl.sv
rtl/mbts_dp.sv
rtl/modbus_tcp_register_server_core.sv
test/tb_top.sv
